@@ rtl/tflc_pkg.sv @@
// Shared types, widths, register codes and reset values of the thermal fan and LED controller.
`default_nettype none

package tflc_pkg;

   localparam int unsigned WINDOW_MAX_DEF = 8;

   localparam int unsigned TEMP_W  = 8;
   localparam int unsigned THR_W   = 7;
   localparam int unsigned LEN_W   = 4;
   localparam int unsigned BRT_W   = 5;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 7;

   // 255 * 31 * 127 fits in 20 bits, 31 * 127 fits in 12 bits.
   localparam int unsigned NUM_W   = 20;
   localparam int unsigned DEN_W   = 12;
   localparam int unsigned QUOT_W  = 8;
   localparam int unsigned SCALE_W = BRT_W + 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ON_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS    = 2'd3;

   localparam logic [THR_W-1:0] ON_THRESHOLD_RST  = 7'd60;
   localparam logic [THR_W-1:0] OFF_THRESHOLD_RST = 7'd50;
   localparam logic [LEN_W-1:0] WINDOW_LEN_RST    = 4'd3;
   localparam logic [BRT_W-1:0] BRIGHTNESS_RST    = 5'd0;

   localparam logic [BYTE_W-1:0] LED_HEADER_BASE = 8'hE0;
   localparam logic [BYTE_W-1:0] LED_BLUE_VALUE  = 8'h00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP_RED,
      ST_WAIT_RED,
      ST_PREP_GREEN,
      ST_WAIT_GREEN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic fan_on;
      logic above_on;
      logic all_low;
   } win_status_type;

   typedef struct packed {
      logic              busy;
      logic [QUOT_W-1:0] quot;
   } div_status_type;

endpackage

`default_nettype wire

@@ rtl/tflc_if.sv @@
// Handshake channel interfaces for sample items, result items and register writes.
`default_nettype none

interface tflc_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [tflc_pkg::TEMP_W-1:0]       temp_c;
   logic                                     force_on;

   modport source (output valid, output temp_c, output force_on, input ready);
   modport sink   (input valid, input temp_c, input force_on, output ready);
endinterface

interface tflc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            fan_on;
   logic                            above_on;
   logic                            all_low;
   logic [tflc_pkg::BYTE_W-1:0]     led_header;
   logic [tflc_pkg::BYTE_W-1:0]     led_blue;
   logic [tflc_pkg::BYTE_W-1:0]     led_green;
   logic [tflc_pkg::BYTE_W-1:0]     led_red;

   modport source (output valid, output fan_on, output above_on, output all_low,
                   output led_header, output led_blue, output led_green, output led_red,
                   input ready);
   modport sink   (input valid, input fan_on, input above_on, input all_low,
                   input led_header, input led_blue, input led_green, input led_red,
                   output ready);
endinterface

interface tflc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tflc_pkg::CSR_IDX_W-1:0]      index;
   logic [tflc_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/tflc_window.sv @@
// Sample window shift register with a serial scan for the hysteresis checks and fan state.
`default_nettype none

module tflc_window #(
   parameter int unsigned WINDOW_MAX = tflc_pkg::WINDOW_MAX_DEF
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     start,
   input  wire logic signed [tflc_pkg::TEMP_W-1:0] temp_c,
   input  wire                                     force_on,
   input  wire logic [tflc_pkg::THR_W-1:0]         on_thr,
   input  wire logic [tflc_pkg::THR_W-1:0]         off_thr,
   input  wire logic [tflc_pkg::LEN_W-1:0]         window_len,
   output tflc_pkg::win_status_type                status
);

   localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   logic signed [tflc_pkg::TEMP_W-1:0] window_ff [WINDOW_MAX];
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] last_ff;
   logic [IDX_W-1:0] last_in;
   logic             busy_ff;
   logic             force_ff;
   logic             acc_high_ff;
   logic             acc_low_ff;
   logic             fan_ff;
   logic             above_on_ff;
   logic             all_low_ff;
   logic             fan_in;
   logic             high_in;
   logic             low_in;
   logic             is_high;
   logic             is_low;
   logic signed [tflc_pkg::TEMP_W-1:0] sample;
   logic [tflc_pkg::LEN_W-1:0] len_m1;

   // Window length zero counts as one, and lengths past the store count as all of it.
   always_comb begin
      len_m1 = window_len - tflc_pkg::LEN_W'(1);
      if (window_len == '0) begin
         last_in = '0;
      end else if (int'(window_len) > int'(WINDOW_MAX)) begin
         last_in = IDX_W'(WINDOW_MAX - 1);
      end else begin
         last_in = IDX_W'(len_m1);
      end
   end

   always_comb begin
      sample  = window_ff[idx_ff];
      is_high = sample > $signed({1'b0, on_thr});
      is_low  = sample < $signed({1'b0, off_thr});
      high_in = (acc_high_ff & is_high) | force_ff;
      low_in  = acc_low_ff & is_low;
      if (high_in && !fan_ff) begin
         fan_in = 1'b1;
      end else if (low_in && fan_ff) begin
         fan_in = 1'b0;
      end else begin
         fan_in = fan_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(WINDOW_MAX); i++) begin
            window_ff[i] <= '0;
         end
         busy_ff     <= 1'b0;
         fan_ff      <= 1'b0;
         idx_ff      <= '0;
      end else if (start) begin
         window_ff[0] <= temp_c;
         for (int i = 1; i < int'(WINDOW_MAX); i++) begin
            window_ff[i] <= window_ff[i-1];
         end
         busy_ff     <= 1'b1;
         idx_ff      <= '0;
      end else if (busy_ff) begin
         if (idx_ff == last_ff) begin
            busy_ff <= 1'b0;
            fan_ff  <= fan_in;
         end else begin
            idx_ff  <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         last_ff     <= last_in;
         force_ff    <= force_on;
         acc_high_ff <= 1'b1;
         acc_low_ff  <= 1'b1;
      end else if (busy_ff) begin
         acc_high_ff <= acc_high_ff & is_high;
         acc_low_ff  <= acc_low_ff & is_low;
         if (idx_ff == last_ff) begin
            above_on_ff <= high_in;
            all_low_ff  <= low_in;
         end
      end
   end

   assign status.busy     = busy_ff;
   assign status.fan_on   = fan_ff;
   assign status.above_on = above_on_ff;
   assign status.all_low  = all_low_ff;

endmodule

`default_nettype wire

@@ rtl/tflc_divider.sv @@
// Restoring divider that produces one quotient bit per cycle for the LED color ratio.
`default_nettype none

module tflc_divider (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire logic [tflc_pkg::NUM_W-1:0]     numer,
   input  wire logic [tflc_pkg::DEN_W-1:0]     denom,
   output tflc_pkg::div_status_type            status
);

   localparam int unsigned SH_W  = tflc_pkg::DEN_W + tflc_pkg::QUOT_W - 1;
   localparam int unsigned CNT_W = $clog2(tflc_pkg::QUOT_W + 1);

   logic [tflc_pkg::NUM_W-1:0]  rem_ff;
   logic [SH_W-1:0]             den_ff;
   logic [tflc_pkg::QUOT_W-1:0] quot_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        busy_ff;
   logic [tflc_pkg::NUM_W:0]    diff;
   logic                        fits;

   // The quotient always fits in eight bits, so the divisor starts shifted by seven.
   always_comb begin
      diff = {1'b0, rem_ff} - (tflc_pkg::NUM_W + 1)'(den_ff);
      fits = !diff[tflc_pkg::NUM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(tflc_pkg::QUOT_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= numer;
         den_ff  <= {denom, {(tflc_pkg::QUOT_W - 1){1'b0}}};
         quot_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= diff[tflc_pkg::NUM_W-1:0];
         end
         den_ff  <= den_ff >> 1;
         quot_ff <= {quot_ff[tflc_pkg::QUOT_W-2:0], fits};
      end
   end

   assign status.busy = busy_ff;
   assign status.quot = quot_ff;

endmodule

`default_nettype wire

@@ rtl/thermal_fan_led_controller_unit.sv @@
// Top level: accepts a sample, shifts it into the window and serially computes fan and LED bytes.
// Each item passes through two 8-bit restoring divisions (red, then green) that share one
// divider at one quotient bit a cycle; the result is registered once both are done.
// A new item is accepted only after the last result is loaded; the window scan runs alongside.
// A finished result waits in the output register while the next item is accepted.
// Reset (synchronous, active high) zeroes the sample window, stops the fan, loads the
// register defaults and empties the output register.
`default_nettype none

module thermal_fan_led_controller_unit #(
   parameter int unsigned WINDOW_MAX = tflc_pkg::WINDOW_MAX_DEF
) (
   input  wire        clock,
   input  wire        reset,
   tflc_req_if.sink   req_ch,
   tflc_rsp_if.source rsp_ch,
   tflc_csr_if.sink   csr_ch
);

   localparam int unsigned THR_W = tflc_pkg::THR_W;

   tflc_pkg::state_type       state_ff, state_in;
   tflc_pkg::win_status_type  win_status;
   tflc_pkg::div_status_type  div_status;

   logic [THR_W-1:0]          on_thr_ff;
   logic [THR_W-1:0]          off_thr_ff;
   logic [tflc_pkg::LEN_W-1:0] win_len_ff;
   logic [tflc_pkg::BRT_W-1:0] brt_ff;

   logic [THR_W-1:0]          span_ff, span_in;
   logic [THR_W-1:0]          m_red_ff, m_red_in;
   logic [THR_W-1:0]          m_green_ff, m_green_in;
   logic [tflc_pkg::QUOT_W-1:0] red_ff;

   logic                      rsp_valid_ff;
   logic                      fan_out_ff;
   logic                      high_out_ff;
   logic                      low_out_ff;
   logic [tflc_pkg::BYTE_W-1:0] green_out_ff;
   logic [tflc_pkg::BYTE_W-1:0] red_out_ff;

   logic                      req_fire;
   logic                      div_start;
   logic                      load_out;
   logic                      store_red;
   logic [THR_W-1:0]          m_sel;
   logic [tflc_pkg::SCALE_W-1:0] scale;
   logic [tflc_pkg::NUM_W-1:0]   numer;
   logic [tflc_pkg::DEN_W-1:0]   denom;

   logic [THR_W-1:0]          tc;
   logic [THR_W-1:0]          dist_r;
   logic [THR_W-1:0]          dist_g;
   logic [THR_W-1:0]          span_raw;
   logic [THR_W:0]            dbl_r;
   logic [THR_W:0]            dbl_g;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = (state_ff == tflc_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_thr_ff  <= tflc_pkg::ON_THRESHOLD_RST;
         off_thr_ff <= tflc_pkg::OFF_THRESHOLD_RST;
         win_len_ff <= tflc_pkg::WINDOW_LEN_RST;
         brt_ff     <= tflc_pkg::BRIGHTNESS_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            tflc_pkg::CSR_ON_THRESHOLD:  on_thr_ff  <= csr_ch.data[THR_W-1:0];
            tflc_pkg::CSR_OFF_THRESHOLD: off_thr_ff <= csr_ch.data[THR_W-1:0];
            tflc_pkg::CSR_WINDOW_LEN:    win_len_ff <= csr_ch.data[tflc_pkg::LEN_W-1:0];
            tflc_pkg::CSR_BRIGHTNESS:    brt_ff     <= csr_ch.data[tflc_pkg::BRT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the sample to the threshold range and take the doubled distances to each end,
   // capped at the span. Unordered thresholds give a span of one with full red.
   always_comb begin
      if (req_ch.temp_c < $signed({1'b0, off_thr_ff})) begin
         tc = off_thr_ff;
      end else if (req_ch.temp_c > $signed({1'b0, on_thr_ff})) begin
         tc = on_thr_ff;
      end else begin
         tc = req_ch.temp_c[THR_W-1:0];
      end
      span_raw = on_thr_ff - off_thr_ff;
      dist_r   = tc - off_thr_ff;
      dist_g   = on_thr_ff - tc;
      dbl_r    = {dist_r, 1'b0};
      dbl_g    = {dist_g, 1'b0};
      if (on_thr_ff > off_thr_ff) begin
         span_in    = span_raw;
         m_red_in   = (dbl_r > {1'b0, span_raw}) ? span_raw : dbl_r[THR_W-1:0];
         m_green_in = (dbl_g > {1'b0, span_raw}) ? span_raw : dbl_g[THR_W-1:0];
      end else begin
         span_in    = THR_W'(1);
         m_red_in   = THR_W'(1);
         m_green_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         span_ff    <= span_in;
         m_red_ff   <= m_red_in;
         m_green_ff <= m_green_in;
      end
      if (store_red) begin
         red_ff <= div_status.quot;
      end
   end

   // Numerator 255 * brightness * m and denominator 31 * span for the divider.
   always_comb begin
      m_sel = (state_ff == tflc_pkg::ST_PREP_GREEN) ? m_green_ff : m_red_ff;
      scale = {brt_ff, 8'b0} - tflc_pkg::SCALE_W'(brt_ff);
      numer = tflc_pkg::NUM_W'(scale) * tflc_pkg::NUM_W'(m_sel);
      denom = {span_ff, 5'b0} - tflc_pkg::DEN_W'(span_ff);
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      store_red = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         tflc_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = tflc_pkg::ST_PREP_RED;
            end
         end
         tflc_pkg::ST_PREP_RED: begin
            div_start = 1'b1;
            state_in  = tflc_pkg::ST_WAIT_RED;
         end
         tflc_pkg::ST_WAIT_RED: begin
            if (!div_status.busy) begin
               store_red = 1'b1;
               state_in  = tflc_pkg::ST_PREP_GREEN;
            end
         end
         tflc_pkg::ST_PREP_GREEN: begin
            div_start = 1'b1;
            state_in  = tflc_pkg::ST_WAIT_GREEN;
         end
         tflc_pkg::ST_WAIT_GREEN: begin
            if (!div_status.busy) begin
               state_in = tflc_pkg::ST_DONE;
            end
         end
         tflc_pkg::ST_DONE: begin
            if (!win_status.busy && (!rsp_valid_ff || rsp_ch.ready)) begin
               load_out = 1'b1;
               state_in = tflc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tflc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tflc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         fan_out_ff   <= win_status.fan_on;
         high_out_ff  <= win_status.above_on;
         low_out_ff   <= win_status.all_low;
         red_out_ff   <= red_ff;
         green_out_ff <= div_status.quot;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.fan_on     = fan_out_ff;
   assign rsp_ch.above_on   = high_out_ff;
   assign rsp_ch.all_low    = low_out_ff;
   assign rsp_ch.led_header = tflc_pkg::LED_HEADER_BASE | tflc_pkg::BYTE_W'(brt_ff);
   assign rsp_ch.led_blue   = tflc_pkg::LED_BLUE_VALUE;
   assign rsp_ch.led_green  = green_out_ff;
   assign rsp_ch.led_red    = red_out_ff;

   tflc_window #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .start      (req_fire),
      .temp_c     (req_ch.temp_c),
      .force_on   (req_ch.force_on),
      .on_thr     (on_thr_ff),
      .off_thr    (off_thr_ff),
      .window_len (win_len_ff),
      .status     (win_status)
   );

   tflc_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (numer),
      .denom  (denom),
      .status (div_status)
   );

endmodule

`default_nettype wire

@@ verif/tflc_result_checker.sv @@
// Checker for the thermal fan and LED controller: predicts each result item and compares it.
`timescale 1ns / 1ps

module tflc_result_checker #(
   parameter int unsigned WINDOW_MAX = tflc_pkg::WINDOW_MAX_DEF
) (
   input  wire  clock,
   input  wire  reset,
   tflc_req_if  req_ch,
   tflc_rsp_if  rsp_ch,
   tflc_csr_if  csr_ch,
   input  logic run_done,
   output int   results_seen,
   output int   fail_count
);

   typedef struct packed {
      logic                        fan_on;
      logic                        above_on;
      logic                        all_low;
      logic [tflc_pkg::BYTE_W-1:0] led_header;
      logic [tflc_pkg::BYTE_W-1:0] led_blue;
      logic [tflc_pkg::BYTE_W-1:0] led_green;
      logic [tflc_pkg::BYTE_W-1:0] led_red;
   } fan_led_frame_type;

   logic [tflc_pkg::THR_W-1:0]         on_thr;
   logic [tflc_pkg::THR_W-1:0]         off_thr;
   logic [tflc_pkg::LEN_W-1:0]         win_len;
   logic [tflc_pkg::BRT_W-1:0]         brt;
   logic signed [tflc_pkg::TEMP_W-1:0] recent_temps [WINDOW_MAX];
   logic                               fan_state;
   fan_led_frame_type                  predicted_frames [$];
   bit                                 leftover_checked;

   // One color byte: brightness scaled by the clamped distance from one end of the span.
   function automatic int unsigned color_level(input int unsigned br, input int unsigned span,
                                               input int unsigned reach);
      int unsigned m;
      m = 2 * reach;
      if (m > span) m = span;
      return (255 * br * m) / (31 * span);
   endfunction

   function automatic fan_led_frame_type predict_frame(
         input logic signed [tflc_pkg::TEMP_W-1:0] t, input logic f);
      fan_led_frame_type fr;
      int                hi;
      int                lo;
      int                n;
      int                tc;
      bit                hot_all;
      bit                cold_all;
      hi = int'(on_thr);
      lo = int'(off_thr);
      n  = int'(win_len);
      if (n < 1) n = 1;
      if (n > WINDOW_MAX) n = WINDOW_MAX;
      for (int i = WINDOW_MAX - 1; i > 0; i--) recent_temps[i] = recent_temps[i-1];
      recent_temps[0] = t;
      hot_all  = 1'b1;
      cold_all = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (!(int'(recent_temps[i]) > hi)) hot_all = 1'b0;
         if (!(int'(recent_temps[i]) < lo)) cold_all = 1'b0;
      end
      if (f) hot_all = 1'b1;
      // Switching on wins when both conditions hold; a running fan then switches off.
      if (hot_all && !fan_state) fan_state = 1'b1;
      else if (cold_all && fan_state) fan_state = 1'b0;

      fr.fan_on     = fan_state;
      fr.above_on   = hot_all;
      fr.all_low    = cold_all;
      fr.led_header = tflc_pkg::LED_HEADER_BASE | tflc_pkg::BYTE_W'(brt);
      fr.led_blue   = tflc_pkg::LED_BLUE_VALUE;
      if (hi <= lo) begin
         fr.led_red   = tflc_pkg::BYTE_W'((255 * int'(brt)) / 31);
         fr.led_green = '0;
      end else begin
         tc = (int'(t) < lo) ? lo : ((int'(t) > hi) ? hi : int'(t));
         fr.led_red   = tflc_pkg::BYTE_W'(color_level(brt, hi - lo, tc - lo));
         fr.led_green = tflc_pkg::BYTE_W'(color_level(brt, hi - lo, hi - tc));
      end
      return fr;
   endfunction

   always @(posedge clock) begin
      fan_led_frame_type got;
      fan_led_frame_type want;
      if (reset) begin
         on_thr    = tflc_pkg::ON_THRESHOLD_RST;
         off_thr   = tflc_pkg::OFF_THRESHOLD_RST;
         win_len   = tflc_pkg::WINDOW_LEN_RST;
         brt       = tflc_pkg::BRIGHTNESS_RST;
         fan_state = 1'b0;
         for (int i = 0; i < WINDOW_MAX; i++) recent_temps[i] = '0;
         predicted_frames.delete();
         results_seen     = 0;
         fail_count       = 0;
         leftover_checked = 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               tflc_pkg::CSR_ON_THRESHOLD:  on_thr  = csr_ch.data[tflc_pkg::THR_W-1:0];
               tflc_pkg::CSR_OFF_THRESHOLD: off_thr = csr_ch.data[tflc_pkg::THR_W-1:0];
               tflc_pkg::CSR_WINDOW_LEN:    win_len = csr_ch.data[tflc_pkg::LEN_W-1:0];
               tflc_pkg::CSR_BRIGHTNESS:    brt     = csr_ch.data[tflc_pkg::BRT_W-1:0];
               default: ;
            endcase
         end

         // Results are matched before this edge's sample is predicted, so a result
         // can never pair with the item accepted at the same edge.
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.fan_on, rsp_ch.above_on, rsp_ch.all_low, rsp_ch.led_header,
                    rsp_ch.led_blue, rsp_ch.led_green, rsp_ch.led_red};
            if (predicted_frames.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result item %0d arrived with none expected", $realtime,
                           results_seen);
               fail_count++;
            end else begin
               want = predicted_frames[0];
               predicted_frames.delete(0);
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"%0t: result item %0d mismatch: expected fan=%0b high=%0b ",
                               "low=%0b hdr=%02h b=%02h g=%02h r=%02h, got fan=%0b high=%0b ",
                               "low=%0b hdr=%02h b=%02h g=%02h r=%02h"},
                              $realtime, results_seen,
                              want.fan_on, want.above_on, want.all_low, want.led_header,
                              want.led_blue, want.led_green, want.led_red,
                              got.fan_on, got.above_on, got.all_low, got.led_header,
                              got.led_blue, got.led_green, got.led_red);
                  fail_count++;
               end
            end
            results_seen++;
         end

         if (req_ch.valid && req_ch.ready)
            predicted_frames.insert(predicted_frames.size(),
                                    predict_frame(req_ch.temp_c, req_ch.force_on));

         if (run_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (predicted_frames.size() != 0) begin
               $display("%0t: %0d expected result items never arrived", $realtime,
                        predicted_frames.size());
               fail_count += predicted_frames.size();
            end
         end
      end
   end

endmodule

@@ verif/thermal_fan_led_controller_unit_tb.sv @@
// Testbench top for the thermal fan and LED controller: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module thermal_fan_led_controller_unit_tb;

   localparam int RANDOM_ITEMS    = 1850;
   localparam int PRESSURE_CYCLES = 400;
   localparam int END_CYCLES      = 40;

   typedef enum int {RUN_NEAR, RUN_HOT, RUN_COLD, RUN_WILD} temp_run_type;

   logic clock;
   logic reset;
   logic run_done;
   bit   steady;
   int   samples_sent;
   int   results_seen;
   int   fail_count;

   tflc_req_if req_ch ();
   tflc_rsp_if rsp_ch ();
   tflc_csr_if csr_ch ();

   thermal_fan_led_controller_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   tflc_result_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_ch       (csr_ch),
      .run_done     (run_done),
      .results_seen (results_seen),
      .fail_count   (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("thermal_fan_led_controller_unit_tb: done, errors");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [tflc_pkg::CSR_DATA_W-1:0] pick_threshold();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return 7'd127;
      if (r < 40) return tflc_pkg::CSR_DATA_W'($urandom_range(0, 127));
      return tflc_pkg::CSR_DATA_W'($urandom_range(30, 90));
   endfunction

   function automatic logic signed [tflc_pkg::TEMP_W-1:0] pick_temp(input temp_run_type kind,
                                                                    input int hi, input int lo);
      int t;
      case (kind)
         RUN_HOT:  t = hi + $urandom_range(1, 20);
         RUN_COLD: t = lo - $urandom_range(1, 20);
         RUN_NEAR: t = ((hi < lo) ? hi : lo) - 3
                       + $urandom_range(0, (hi > lo ? hi - lo : lo - hi) + 6);
         default:  t = int'($urandom_range(0, 255)) - 128;
      endcase
      if (t > 127) t = 127;
      if (t < -128) t = -128;
      return tflc_pkg::TEMP_W'(t);
   endfunction

   task automatic send_sample(input logic signed [tflc_pkg::TEMP_W-1:0] t, input logic f);
      int gap;
      req_ch.valid    <= 1'b1;
      req_ch.temp_c   <= t;
      req_ch.force_on <= f;
      do @(posedge clock); while (!req_ch.ready);
      samples_sent++;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (results_seen != samples_sent) @(posedge clock);
   endtask

   // Writes all four registers back to back; valid stays high across the writes.
   task automatic set_regs(input logic [tflc_pkg::CSR_DATA_W-1:0] on_v,
                           input logic [tflc_pkg::CSR_DATA_W-1:0] off_v,
                           input logic [tflc_pkg::CSR_DATA_W-1:0] len_v,
                           input logic [tflc_pkg::CSR_DATA_W-1:0] brt_v);
      logic [tflc_pkg::CSR_IDX_W-1:0]  idx  [4];
      logic [tflc_pkg::CSR_DATA_W-1:0] vals [4];
      idx  = '{tflc_pkg::CSR_ON_THRESHOLD, tflc_pkg::CSR_OFF_THRESHOLD,
               tflc_pkg::CSR_WINDOW_LEN, tflc_pkg::CSR_BRIGHTNESS};
      vals = '{on_v, off_v, len_v, brt_v};
      for (int i = 0; i < 4; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[i];
         csr_ch.data  <= vals[i];
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
   endtask

   // Result side: random hold-offs, plus long stalls that back the block up into its input.
   initial begin
      int hold_left;
      int open_left;
      int rx_count;
      int next_pressure;
      hold_left     = 0;
      open_left     = 0;
      rx_count      = 0;
      next_pressure = 300;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) rx_count++;
         if (rx_count >= next_pressure) begin
            hold_left     = PRESSURE_CYCLES;
            next_pressure = next_pressure + 900;
         end
         if (hold_left == 0 && open_left == 0) begin
            hold_left = steady ? 0 : pick_gap();
            open_left = $urandom_range(1, 8);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            open_left--;
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      int                              items_done;
      int                              phase_len;
      int                              run_left;
      int                              r;
      int                              cur_on;
      int                              cur_off;
      temp_run_type                    run_kind;
      logic [tflc_pkg::CSR_DATA_W-1:0] on_v;
      logic [tflc_pkg::CSR_DATA_W-1:0] off_v;
      logic [tflc_pkg::CSR_DATA_W-1:0] len_v;
      logic [tflc_pkg::CSR_DATA_W-1:0] brt_v;

      samples_sent = 0;
      steady       = 1'b0;
      run_done        <= 1'b0;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.temp_c   <= '0;
      req_ch.force_on <= 1'b0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= tflc_pkg::CSR_ON_THRESHOLD;
      csr_ch.data     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Register defaults straight after reset: three hot samples fill the window.
      send_sample(8'sd61, 1'b0);
      send_sample(8'sd61, 1'b0);
      send_sample(8'sd61, 1'b0);
      wait_drained();

      // Clamping at both ends, the threshold edges, switch-off and the force override.
      set_regs(7'd60, 7'd50, 7'd3, 7'd31);
      send_sample(-8'sd128, 1'b0);
      send_sample(8'sd127, 1'b0);
      send_sample(8'sd55, 1'b0);
      send_sample(8'sd50, 1'b0);
      send_sample(8'sd60, 1'b0);
      send_sample(8'sd45, 1'b0);
      send_sample(8'sd45, 1'b0);
      send_sample(8'sd45, 1'b0);
      send_sample(8'sd0, 1'b1);
      wait_drained();

      // Reversed thresholds give pure red; a zero window length acts as one, and a
      // sample between the reversed thresholds is both high and low at once.
      set_regs(7'd40, 7'd70, 7'd0, 7'h3F);
      send_sample(8'sd80, 1'b0);
      send_sample(8'sd30, 1'b0);
      send_sample(8'sd50, 1'b0);
      send_sample(8'sd50, 1'b0);
      send_sample(8'sd127, 1'b0);
      wait_drained();

      // Oversized window length clamps to the full window; widest span.
      set_regs(7'd127, 7'd0, 7'h7F, 7'd17);
      send_sample(8'sd127, 1'b0);
      send_sample(8'sd0, 1'b0);
      send_sample(-8'sd1, 1'b0);
      send_sample(8'sd64, 1'b0);
      wait_drained();

      // Equal thresholds with zero brightness.
      set_regs(7'd10, 7'd10, 7'd8, 7'd0);
      send_sample(8'sd10, 1'b0);
      send_sample(8'sd9, 1'b0);

      items_done = 0;
      run_left   = 0;
      run_kind   = RUN_NEAR;
      while (items_done < RANDOM_ITEMS) begin
         wait_drained();
         on_v  = pick_threshold();
         off_v = pick_threshold();
         // Keep most settings properly ordered so the hysteresis gets exercised.
         if (on_v < off_v && $urandom_range(0, 99) < 70) begin
            {on_v, off_v} = {off_v, on_v};
         end
         r = $urandom_range(0, 99);
         if (r < 15) len_v = '0;
         else if (r < 30) len_v = tflc_pkg::CSR_DATA_W'($urandom_range(9, 15));
         else if (r < 45) len_v = tflc_pkg::CSR_DATA_W'($urandom_range(0, 127));
         else len_v = tflc_pkg::CSR_DATA_W'($urandom_range(1, 8));
         r = $urandom_range(0, 99);
         if (r < 15) brt_v = '0;
         else if (r < 30) brt_v = 7'd31;
         else if (r < 50) brt_v = tflc_pkg::CSR_DATA_W'($urandom_range(0, 127));
         else brt_v = tflc_pkg::CSR_DATA_W'($urandom_range(1, 30));
         set_regs(on_v, off_v, len_v, brt_v);
         cur_on  = int'(on_v);
         cur_off = int'(off_v);
         steady    = ($urandom_range(0, 4) == 0);
         phase_len = $urandom_range(30, 120);
         for (int k = 0; k < phase_len && items_done < RANDOM_ITEMS; k++) begin
            if (run_left == 0) begin
               r = $urandom_range(0, 99);
               if (r < 40) run_kind = RUN_NEAR;
               else if (r < 65) run_kind = RUN_HOT;
               else if (r < 88) run_kind = RUN_COLD;
               else run_kind = RUN_WILD;
               run_left = $urandom_range(3, 14);
            end
            run_left--;
            send_sample(pick_temp(run_kind, cur_on, cur_off), $urandom_range(0, 19) == 0);
            items_done++;
         end
      end
      wait_drained();
      steady = 1'b0;
      run_done <= 1'b1;
      repeat (END_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("thermal_fan_led_controller_unit_tb: done, clean");
      else
         $display("thermal_fan_led_controller_unit_tb: done, errors");
      $finish;
   end

endmodule
